// ===== hw/rtl/tpsl_pkg.sv =====
`timescale 1ns / 1ps

package tpsl_pkg;

    localparam int MV_W    = 14;   // sender voltage, signed
    localparam int CV_W    = 13;   // calibration voltage, unsigned
    localparam int ANG_W   = 15;   // angle, signed centidegrees
    localparam int DV_W    = 16;   // voltage offset within segment
    localparam int DA_W    = 17;   // angle difference across segment
    localparam int SPAN_W  = 14;   // signed segment width
    localparam int PROD_W  = 33;   // signed product
    localparam int MAG_W   = 32;   // product magnitude and quotient
    localparam int DVS_W   = 13;   // divisor magnitude
    localparam int SUM_W   = 34;   // base angle plus signed quotient
    localparam int NEG_W   = 16;   // negated angle before second clamp

    localparam int DIV_STEP   = 4;                  // quotient bits per stage
    localparam int DIV_STAGES = MAG_W / DIV_STEP;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 15;

    localparam logic [CFG_IDX_W-1:0] CFG_VOLT_MIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VOLT_CTR   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VOLT_MAX   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_LOW  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_MID  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_HIGH = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_NEGATE     = 3'd6;

    localparam logic        [CV_W-1:0]  RST_VOLT_MIN   = 13'd500;
    localparam logic        [CV_W-1:0]  RST_VOLT_CTR   = 13'd2500;
    localparam logic        [CV_W-1:0]  RST_VOLT_MAX   = 13'd4500;
    localparam logic signed [ANG_W-1:0] RST_ANGLE_LOW  = -15'sd4500;
    localparam logic signed [ANG_W-1:0] RST_ANGLE_MID  = 15'sd0;
    localparam logic signed [ANG_W-1:0] RST_ANGLE_HIGH = 15'sd4500;

    // one divider stage: partial remainder, dividend shifting out / quotient shifting in
    typedef struct packed {
        logic        [DVS_W-1:0] rem;
        logic        [MAG_W-1:0] quo;
        logic        [DVS_W-1:0] dvs;
        logic                    neg;
        logic                    zero;
        logic signed [ANG_W-1:0] a0;
    } t_div;

endpackage

// ===== hw/rtl/three_point_sensor_linearizer_core.sv =====
`timescale 1ns / 1ps

// Three-point sensor linearizer. Each sender voltage (mV) is mapped to an angle in
// centidegrees by linear interpolation over the segment min..centre or centre..max,
// chosen by comparing against the centre voltage; the result is clamped to the low/high
// angle limits, optionally negated and clamped again, and o_clamped flags any clamping.
// One item is accepted per clock while o_in_stall is low; the quotient is resolved
// 4 bits per stage over eight divider stages. Every stage has its own valid bit, so
// bubbles close up and new items are taken while a finished result waits. Calibration
// registers reset to 500/2500/4500 mV, -45.00/0/+45.00 deg, no negation; write them
// only while idle. A write to index 7 is ignored and o_cfg_ready is always high.
module three_point_sensor_linearizer_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic signed [tpsl_pkg::MV_W-1:0]     i_sender_mv,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [tpsl_pkg::ANG_W-1:0]    o_angle_cdeg,
    output logic                                 o_clamped,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic        [tpsl_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic        [tpsl_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int P_DIV0   = 3;
    localparam int P_SUM    = P_DIV0 + tpsl_pkg::DIV_STAGES + 1;
    localparam int P_CLAMP1 = P_SUM + 1;
    localparam int P_OUT    = P_CLAMP1 + 1;
    localparam int NPOS     = P_OUT + 1;

    // calibration registers
    logic        [tpsl_pkg::CV_W-1:0]  r_vmin, r_vctr, r_vmax;
    logic signed [tpsl_pkg::ANG_W-1:0] r_alo, r_amid, r_ahi;
    logic                              r_negate;

    logic [NPOS-1:0] r_vld;
    logic [NPOS-1:0] ld;

    logic signed [tpsl_pkg::MV_W-1:0]   r_s0_mv;
    logic signed [tpsl_pkg::DV_W-1:0]   r_s1_dv;
    logic signed [tpsl_pkg::DA_W-1:0]   r_s1_da;
    logic signed [tpsl_pkg::SPAN_W-1:0] r_s1_span;
    logic signed [tpsl_pkg::ANG_W-1:0]  r_s1_a0;
    logic signed [tpsl_pkg::PROD_W-1:0] r_s2_prod;
    logic signed [tpsl_pkg::SPAN_W-1:0] r_s2_span;
    logic signed [tpsl_pkg::ANG_W-1:0]  r_s2_a0;
    tpsl_pkg::t_div                     r_div [tpsl_pkg::DIV_STAGES+1];
    logic signed [tpsl_pkg::SUM_W-1:0]  r_s12_sum;
    logic signed [tpsl_pkg::ANG_W-1:0]  r_s13_ang;
    logic                               r_s13_flag;
    logic signed [tpsl_pkg::ANG_W-1:0]  r_out_angle;
    logic                               r_out_clamped;

    logic signed [tpsl_pkg::DV_W-1:0]   n_dv;
    logic signed [tpsl_pkg::DA_W-1:0]   n_da;
    logic signed [tpsl_pkg::SPAN_W-1:0] n_span;
    logic signed [tpsl_pkg::ANG_W-1:0]  n_a0;
    logic signed [tpsl_pkg::PROD_W-1:0] n_prod;
    tpsl_pkg::t_div                     n_div0;
    logic signed [tpsl_pkg::PROD_W-1:0] abs_prod;
    logic signed [tpsl_pkg::SPAN_W-1:0] abs_span;
    logic signed [tpsl_pkg::SUM_W-1:0]  n_sum;
    logic signed [tpsl_pkg::SUM_W-1:0]  sq;
    logic signed [tpsl_pkg::SUM_W-1:0]  c1_x, c1_lo, c1_hi;
    logic                               n_c1_flag;
    logic signed [tpsl_pkg::NEG_W-1:0]  c2_x, c2_lo, c2_hi;
    logic                               n_c2_flag;

    // four restoring division steps on the magnitudes
    function automatic tpsl_pkg::t_div div_step(input tpsl_pkg::t_div s);
        tpsl_pkg::t_div         r;
        logic [tpsl_pkg::DVS_W:0] t;
        r = s;
        for (int b = 0; b < tpsl_pkg::DIV_STEP; b++) begin
            t     = {r.rem, r.quo[tpsl_pkg::MAG_W-1]};
            r.quo = {r.quo[tpsl_pkg::MAG_W-2:0], 1'b0};
            if (t >= {1'b0, r.dvs}) begin
                t        = t - {1'b0, r.dvs};
                r.quo[0] = 1'b1;
            end
            r.rem = t[tpsl_pkg::DVS_W-1:0];
        end
        return r;
    endfunction

    // a stage loads when empty or when the stage after it moves on
    always_comb begin
        ld[NPOS-1] = !r_vld[NPOS-1] || !i_out_stall;
        for (int k = NPOS - 2; k >= 0; k--) begin
            ld[k] = !r_vld[k] || ld[k+1];
        end
    end

    assign o_in_stall   = !ld[0];
    assign o_out_valid  = r_vld[NPOS-1];
    assign o_angle_cdeg = r_out_angle;
    assign o_clamped    = r_out_clamped;
    assign o_cfg_ready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_vmin   <= tpsl_pkg::RST_VOLT_MIN;
            r_vctr   <= tpsl_pkg::RST_VOLT_CTR;
            r_vmax   <= tpsl_pkg::RST_VOLT_MAX;
            r_alo    <= tpsl_pkg::RST_ANGLE_LOW;
            r_amid   <= tpsl_pkg::RST_ANGLE_MID;
            r_ahi    <= tpsl_pkg::RST_ANGLE_HIGH;
            r_negate <= 1'b0;
        end else begin
            if (ld[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int k = 1; k < NPOS; k++) begin
                if (ld[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    tpsl_pkg::CFG_VOLT_MIN:   r_vmin   <= i_cfg_data[tpsl_pkg::CV_W-1:0];
                    tpsl_pkg::CFG_VOLT_CTR:   r_vctr   <= i_cfg_data[tpsl_pkg::CV_W-1:0];
                    tpsl_pkg::CFG_VOLT_MAX:   r_vmax   <= i_cfg_data[tpsl_pkg::CV_W-1:0];
                    tpsl_pkg::CFG_ANGLE_LOW:  r_alo    <= $signed(i_cfg_data);
                    tpsl_pkg::CFG_ANGLE_MID:  r_amid   <= $signed(i_cfg_data);
                    tpsl_pkg::CFG_ANGLE_HIGH: r_ahi    <= $signed(i_cfg_data);
                    tpsl_pkg::CFG_NEGATE:     r_negate <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    // segment choice and offsets
    always_comb begin
        if (r_s0_mv <= $signed({1'b0, r_vctr})) begin
            n_dv   = $signed({{2{r_s0_mv[tpsl_pkg::MV_W-1]}}, r_s0_mv})
                   - $signed({3'b000, r_vmin});
            n_span = $signed({1'b0, r_vctr}) - $signed({1'b0, r_vmin});
            n_a0   = r_alo;
            n_da   = $signed({{2{r_amid[tpsl_pkg::ANG_W-1]}}, r_amid})
                   - $signed({{2{r_alo[tpsl_pkg::ANG_W-1]}}, r_alo});
        end else begin
            n_dv   = $signed({{2{r_s0_mv[tpsl_pkg::MV_W-1]}}, r_s0_mv})
                   - $signed({3'b000, r_vctr});
            n_span = $signed({1'b0, r_vmax}) - $signed({1'b0, r_vctr});
            n_a0   = r_amid;
            n_da   = $signed({{2{r_ahi[tpsl_pkg::ANG_W-1]}}, r_ahi})
                   - $signed({{2{r_amid[tpsl_pkg::ANG_W-1]}}, r_amid});
        end
    end

    assign n_prod = $signed({{(tpsl_pkg::PROD_W-tpsl_pkg::DV_W){r_s1_dv[tpsl_pkg::DV_W-1]}},
                             r_s1_dv})
                  * $signed({{(tpsl_pkg::PROD_W-tpsl_pkg::DA_W){r_s1_da[tpsl_pkg::DA_W-1]}},
                             r_s1_da});

    // signs split off, magnitudes into the divider
    always_comb begin
        abs_prod    = r_s2_prod[tpsl_pkg::PROD_W-1] ? -r_s2_prod : r_s2_prod;
        abs_span    = r_s2_span[tpsl_pkg::SPAN_W-1] ? -r_s2_span : r_s2_span;
        n_div0.rem  = '0;
        n_div0.quo  = abs_prod[tpsl_pkg::MAG_W-1:0];
        n_div0.dvs  = abs_span[tpsl_pkg::DVS_W-1:0];
        n_div0.neg  = r_s2_prod[tpsl_pkg::PROD_W-1] ^ r_s2_span[tpsl_pkg::SPAN_W-1];
        n_div0.zero = (r_s2_span == '0);
        n_div0.a0   = r_s2_a0;
    end

    // truncating quotient back to signed, added to the segment start angle unless the segment has zero width
    always_comb begin
        sq = $signed({2'b00, r_div[tpsl_pkg::DIV_STAGES].quo});
        if (r_div[tpsl_pkg::DIV_STAGES].neg) begin
            sq = -sq;
        end
        n_sum = $signed({{(tpsl_pkg::SUM_W-tpsl_pkg::ANG_W)
                          {r_div[tpsl_pkg::DIV_STAGES].a0[tpsl_pkg::ANG_W-1]}},
                         r_div[tpsl_pkg::DIV_STAGES].a0});
        if (!r_div[tpsl_pkg::DIV_STAGES].zero) begin
            n_sum = n_sum + sq;
        end
    end

    // first clamp, lower then upper
    always_comb begin
        c1_lo     = $signed({{(tpsl_pkg::SUM_W-tpsl_pkg::ANG_W){r_alo[tpsl_pkg::ANG_W-1]}},
                             r_alo});
        c1_hi     = $signed({{(tpsl_pkg::SUM_W-tpsl_pkg::ANG_W){r_ahi[tpsl_pkg::ANG_W-1]}},
                             r_ahi});
        c1_x      = r_s12_sum;
        n_c1_flag = 1'b0;
        if (c1_x < c1_lo) begin
            c1_x      = c1_lo;
            n_c1_flag = 1'b1;
        end
        if (c1_x > c1_hi) begin
            c1_x      = c1_hi;
            n_c1_flag = 1'b1;
        end
    end

    // optional negation and second clamp
    always_comb begin
        c2_lo = $signed({r_alo[tpsl_pkg::ANG_W-1], r_alo});
        c2_hi = $signed({r_ahi[tpsl_pkg::ANG_W-1], r_ahi});
        c2_x  = $signed({r_s13_ang[tpsl_pkg::ANG_W-1], r_s13_ang});
        if (r_negate) begin
            c2_x = -c2_x;
        end
        n_c2_flag = r_s13_flag;
        if (c2_x < c2_lo) begin
            c2_x      = c2_lo;
            n_c2_flag = 1'b1;
        end
        if (c2_x > c2_hi) begin
            c2_x      = c2_hi;
            n_c2_flag = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld[0]) begin
            r_s0_mv <= i_sender_mv;
        end
        if (ld[1]) begin
            r_s1_dv   <= n_dv;
            r_s1_da   <= n_da;
            r_s1_span <= n_span;
            r_s1_a0   <= n_a0;
        end
        if (ld[2]) begin
            r_s2_prod <= n_prod;
            r_s2_span <= r_s1_span;
            r_s2_a0   <= r_s1_a0;
        end
        if (ld[P_DIV0]) begin
            r_div[0] <= n_div0;
        end
        for (int k = 0; k < tpsl_pkg::DIV_STAGES; k++) begin
            if (ld[P_DIV0+k+1]) begin
                r_div[k+1] <= div_step(r_div[k]);
            end
        end
        if (ld[P_SUM]) begin
            r_s12_sum <= n_sum;
        end
        if (ld[P_CLAMP1]) begin
            r_s13_ang  <= c1_x[tpsl_pkg::ANG_W-1:0];
            r_s13_flag <= n_c1_flag;
        end
        if (ld[P_OUT]) begin
            r_out_angle   <= c2_x[tpsl_pkg::ANG_W-1:0];
            r_out_clamped <= n_c2_flag;
        end
    end

endmodule

// ===== tb/tpsl_angle_checker.sv =====
`timescale 1ns / 1ps

module tpsl_angle_checker (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    input  logic                                   i_in_stall,
    input  logic signed [tpsl_pkg::MV_W-1:0]       i_sender_mv,
    input  logic                                   i_out_valid,
    input  logic                                   i_out_stall,
    input  logic signed [tpsl_pkg::ANG_W-1:0]      i_angle_cdeg,
    input  logic                                   i_clamped,
    input  logic                                   i_cfg_valid,
    input  logic                                   i_cfg_ready,
    input  logic        [tpsl_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic        [tpsl_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                                     o_fail_count,
    output int                                     o_pending,
    output int                                     o_checked
);

    typedef struct {
        logic        [tpsl_pkg::CV_W-1:0]  vmin;
        logic        [tpsl_pkg::CV_W-1:0]  vctr;
        logic        [tpsl_pkg::CV_W-1:0]  vmax;
        logic signed [tpsl_pkg::ANG_W-1:0] alo;
        logic signed [tpsl_pkg::ANG_W-1:0] amid;
        logic signed [tpsl_pkg::ANG_W-1:0] ahi;
        logic                              negate;
    } t_cal;

    typedef struct {
        logic signed [tpsl_pkg::MV_W-1:0]  mv;
        logic signed [tpsl_pkg::ANG_W-1:0] angle;
        logic                              clamped;
    } t_angle;

    t_cal   cal;
    t_angle angle_q[$];
    int     fails   = 0;
    int     checked = 0;

    function automatic t_cal cal_after_reset();
        t_cal c;
        c.vmin   = tpsl_pkg::RST_VOLT_MIN;
        c.vctr   = tpsl_pkg::RST_VOLT_CTR;
        c.vmax   = tpsl_pkg::RST_VOLT_MAX;
        c.alo    = tpsl_pkg::RST_ANGLE_LOW;
        c.amid   = tpsl_pkg::RST_ANGLE_MID;
        c.ahi    = tpsl_pkg::RST_ANGLE_HIGH;
        c.negate = 1'b0;
        return c;
    endfunction

    // lower bound first, upper second: with inverted limits the upper one wins
    function automatic longint clamp_angle(longint x, longint lo, longint hi, inout logic hit);
        if (x < lo) begin
            x   = lo;
            hit = 1'b1;
        end
        if (x > hi) begin
            x   = hi;
            hit = 1'b1;
        end
        return x;
    endfunction

    function automatic t_angle linearize(t_cal c, logic signed [tpsl_pkg::MV_W-1:0] mv);
        longint v, vmin, vctr, vmax, alo, amid, ahi;
        longint v0, span, a0, da, ang;
        logic   hit;
        t_angle r;
        v    = mv;
        vmin = c.vmin;
        vctr = c.vctr;
        vmax = c.vmax;
        alo  = c.alo;
        amid = c.amid;
        ahi  = c.ahi;
        hit  = 1'b0;
        if (v <= vctr) begin
            v0   = vmin;
            span = vctr - vmin;
            a0   = alo;
            da   = amid - alo;
        end else begin
            v0   = vctr;
            span = vmax - vctr;
            a0   = amid;
            da   = ahi - amid;
        end
        // zero-width segment sits at its start angle
        ang = a0;
        if (span != 0)
            ang = a0 + ((v - v0) * da) / span;
        ang = clamp_angle(ang, alo, ahi, hit);
        if (c.negate)
            ang = -ang;
        ang = clamp_angle(ang, alo, ahi, hit);
        r.mv      = mv;
        r.angle   = tpsl_pkg::ANG_W'(ang);
        r.clamped = hit;
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_angle want;
        if (!i_rst_n) begin
            cal = cal_after_reset();
            angle_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    tpsl_pkg::CFG_VOLT_MIN:   cal.vmin   = i_cfg_data[tpsl_pkg::CV_W-1:0];
                    tpsl_pkg::CFG_VOLT_CTR:   cal.vctr   = i_cfg_data[tpsl_pkg::CV_W-1:0];
                    tpsl_pkg::CFG_VOLT_MAX:   cal.vmax   = i_cfg_data[tpsl_pkg::CV_W-1:0];
                    tpsl_pkg::CFG_ANGLE_LOW:  cal.alo    = i_cfg_data;
                    tpsl_pkg::CFG_ANGLE_MID:  cal.amid   = i_cfg_data;
                    tpsl_pkg::CFG_ANGLE_HIGH: cal.ahi    = i_cfg_data;
                    tpsl_pkg::CFG_NEGATE:     cal.negate = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (angle_q.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("unexpected angle transfer: angle %0d clamped %0b",
                                 i_angle_cdeg, i_clamped);
                end else begin
                    want = angle_q.pop_front();
                    if (i_angle_cdeg !== want.angle || i_clamped !== want.clamped) begin
                        fails++;
                        if (fails <= 10)
                            $display("mismatch for %0d mV: angle %0d clamped %0b, wanted %0d %0b",
                                     want.mv, i_angle_cdeg, i_clamped,
                                     want.angle, want.clamped);
                    end
                end
                checked++;
            end
            if (i_in_valid && !i_in_stall)
                angle_q.push_back(linearize(cal, i_sender_mv));
        end
        o_pending    <= angle_q.size();
        o_fail_count <= fails;
        o_checked    <= checked;
    end

endmodule

// ===== tb/three_point_sensor_linearizer_core_tb.sv =====
`timescale 1ns / 1ps

module three_point_sensor_linearizer_core_tb;

    localparam int LIMIT   = 200000;
    localparam int MV_TOP  = 6144;
    localparam int CAL_TOP = 6144;
    localparam int ANG_TOP = 9000;
    localparam logic [tpsl_pkg::CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

    logic                                   i_clk       = 1'b0;
    logic                                   i_rst_n;
    logic                                   i_in_valid;
    logic                                   o_in_stall;
    logic signed [tpsl_pkg::MV_W-1:0]       i_sender_mv;
    logic                                   o_out_valid;
    logic                                   i_out_stall = 1'b0;
    logic signed [tpsl_pkg::ANG_W-1:0]      o_angle_cdeg;
    logic                                   o_clamped;
    logic                                   i_cfg_valid;
    logic                                   o_cfg_ready;
    logic        [tpsl_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic        [tpsl_pkg::CFG_DATA_W-1:0] i_cfg_data;

    int fail_count;
    int pending;
    int checked;
    int cycle_count = 0;
    int items_sent  = 0;
    int cal_sets    = 0;
    bit calm        = 1'b0;

    three_point_sensor_linearizer_core DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_sender_mv  (i_sender_mv),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_angle_cdeg (o_angle_cdeg),
        .o_clamped    (o_clamped),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    tpsl_angle_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_sender_mv  (i_sender_mv),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_angle_cdeg (o_angle_cdeg),
        .i_clamped    (o_clamped),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        i_out_stall <= !calm && ($urandom_range(99) < 7);
    end

    initial begin
        wait (cycle_count >= LIMIT);
        $display("timeout after %0d cycles, %0d angles outstanding", cycle_count, pending);
        $display("[FAIL] regression broken");
        $finish;
    end

    // holds valid high across back-to-back transfers, drops it only for a gap
    task automatic send_mv(input int mv);
        if (!calm && $urandom_range(99) < 7) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_sender_mv <= tpsl_pkg::MV_W'(mv);
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        items_sent++;
    endtask

    // sender holds off until every angle in flight has come out
    task automatic wait_drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
    endtask

    // unused upper data bits carry junk, and the spare index is hit every time
    task automatic write_cal(input int vmin, input int vctr, input int vmax,
                             input int alo, input int amid, input int ahi, input bit neg);
        logic [tpsl_pkg::CFG_IDX_W-1:0]  idx [8];
        logic [tpsl_pkg::CFG_DATA_W-1:0] val [8];
        idx = '{tpsl_pkg::CFG_VOLT_MIN, tpsl_pkg::CFG_VOLT_CTR, tpsl_pkg::CFG_VOLT_MAX,
                tpsl_pkg::CFG_ANGLE_LOW, tpsl_pkg::CFG_ANGLE_MID, tpsl_pkg::CFG_ANGLE_HIGH,
                tpsl_pkg::CFG_NEGATE, CFG_SPARE};
        val[0] = {2'($urandom), 13'(vmin)};
        val[1] = {2'($urandom), 13'(vctr)};
        val[2] = {2'($urandom), 13'(vmax)};
        val[3] = 15'(alo);
        val[4] = 15'(amid);
        val[5] = 15'(ahi);
        val[6] = {14'($urandom), neg};
        val[7] = 15'($urandom);
        wait_drain();
        for (int k = 0; k < 8; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx[k];
            i_cfg_data  <= val[k];
            @(posedge i_clk);
            while (!o_cfg_ready)
                @(posedge i_clk);
        end
        i_cfg_valid <= 1'b0;
        cal_sets++;
    endtask

    task automatic random_phase(input int count, input bit ordered, input bit pause_mid);
        int vmin, vctr, vmax, alo, amid, ahi;
        int vlow, vhigh, mv;
        bit neg;
        if (ordered) begin
            vmin = $urandom_range(0, 2048);
            vctr = vmin + $urandom_range(0, 2048);
            vmax = vctr + $urandom_range(0, 2048);
            alo  = -$urandom_range(0, ANG_TOP);
            ahi  = $urandom_range(0, ANG_TOP);
            amid = alo + $urandom_range(0, ahi - alo);
        end else begin
            vmin = $urandom_range(0, CAL_TOP);
            vctr = $urandom_range(0, CAL_TOP);
            vmax = $urandom_range(0, CAL_TOP);
            alo  = $urandom_range(0, 2 * ANG_TOP) - ANG_TOP;
            amid = $urandom_range(0, 2 * ANG_TOP) - ANG_TOP;
            ahi  = $urandom_range(0, 2 * ANG_TOP) - ANG_TOP;
        end
        neg = 1'($urandom_range(1));
        write_cal(vmin, vctr, vmax, alo, amid, ahi, neg);
        vlow  = vmin < vmax ? vmin : vmax;
        vlow  = vctr < vlow ? vctr : vlow;
        vhigh = vmin > vmax ? vmin : vmax;
        vhigh = vctr > vhigh ? vctr : vhigh;
        vlow  = (vlow - 400 < -MV_TOP) ? -MV_TOP : vlow - 400;
        vhigh = (vhigh + 400 > MV_TOP) ? MV_TOP : vhigh + 400;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(99) < 80)
                mv = vlow + $urandom_range(0, vhigh - vlow);
            else
                mv = $urandom_range(0, 2 * MV_TOP) - MV_TOP;
            send_mv(mv);
            if (pause_mid && n == count / 2)
                wait_drain();
        end
    endtask

    initial begin
        int reset_pts[11];
        reset_pts = '{-6144, -1, 0, 499, 500, 1500, 2500, 2501, 4500, 4501, 6144};
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_sender_mv <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // calibration straight out of reset
        foreach (reset_pts[k])
            send_mv(reset_pts[k]);

        // both segments zero width
        write_cal(1000, 1000, 1000, -9000, 300, 9000, 1'b0);
        send_mv(999);
        send_mv(1000);
        send_mv(1001);

        // reversed calibration points, inverted limits, negation
        write_cal(6144, 3000, 0, 9000, 0, -9000, 1'b1);
        send_mv(0);
        send_mv(3000);
        send_mv(6144);
        send_mv(-6144);

        write_cal(0, 0, 0, -9000, -9000, -9000, 1'b0);
        send_mv(-6144);
        send_mv(0);

        write_cal(6144, 6144, 6144, 9000, 9000, 9000, 1'b1);
        send_mv(6144);
        send_mv(0);
        send_mv(-6144);

        write_cal(0, 3072, 6144, -9000, 0, 9000, 1'b1);
        send_mv(6144);
        send_mv(-6144);

        for (int p = 0; p < 8; p++) begin
            calm <= (p == 3);
            random_phase(235, p % 4 != 2, p == 5);
        end

        wait_drain();
        repeat (30) @(posedge i_clk);

        $display("%0d sender samples over %0d calibration sets, %0d angles compared",
                 items_sent, cal_sets, checked);
        $display("covered zero-width and reversed segments, inverted limits, negation, spare index");
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
